### design/assert_macros.svh
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/rcla_pkg.sv
package rcla_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned NUM_CHAN = 3;

  typedef struct packed {
    logic en;
  } pipe_ctl_t;

  typedef enum logic [1:0] {
    LVL_RISE,
    LVL_HIGH,
    LVL_FALL,
    LVL_LOW
  } level_sel_e;

endpackage

### design/rcla_div.sv
module rcla_div import rcla_pkg::*; #(
  parameter int unsigned NW     = 24,
  parameter int unsigned DW     = 9,
  parameter int unsigned QW     = 17,
  parameter int unsigned STAGES = 19
) (
  input  logic          clk_i,
  input  pipe_ctl_t     ctl_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [STAGES];
  logic [QW-1:0] low_q [STAGES];
  logic [QW-1:0] quo_q [STAGES];
  logic [DW-1:0] den_q [STAGES];

  logic [NW-1:0] num_hi;
  assign num_hi = num_i >> QW;

  for (genvar k = 0; k < STAGES; k++) begin : g_st
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW-1:0] rem_d;
    logic [QW-1:0] low_d;
    logic [QW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_hi[DW-1:0];
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    if (k < QW) begin : g_step
      logic [DW:0] trial;
      logic        qbit;
      always_comb begin
        trial = {rem_in, low_in[QW-1]};
        qbit  = (trial >= {1'b0, den_in});
        if (qbit) begin
          rem_d = DW'(trial - {1'b0, den_in});
        end else begin
          rem_d = trial[DW-1:0];
        end
        low_d = {low_in[QW-2:0], 1'b0};
        quo_d = {quo_in[QW-2:0], qbit};
      end
    end else begin : g_hold
      assign rem_d = rem_in;
      assign low_d = low_in;
      assign quo_d = quo_in;
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        rem_q[k] <= rem_d;
        low_q[k] <= low_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[STAGES-1];

endmodule

### design/rgb_contrast_lightness_adjust.sv
// rgb_contrast_lightness_adjust
// Contrast stretch by 1.5 about mid-grey, then lightness scaled by 0.8 in
// HSL space, for one 8-bit RGB colour per request.
// Input channel: in_valid_i / in_ready_o with red_in_i, green_in_i,
// blue_in_i. Output channel: out_valid_o / out_ready_i with red_out_o,
// green_out_o, blue_out_o. One result per request, in request order.
// Throughput: one request per cycle while in_ready_o is high. Two stages
// lie in front of the saturation and hue dividers, which span FRAC_BITS + 3
// stages and resolve one quotient bit per stage (saturation only in the
// first FRAC_BITS + 1), and four behind them and the output register.
// Lightness is a reciprocal multiply delayed to line up with the dividers.
// A skid register behind the output register takes one more result while
// the receiver stalls; in_ready_o drops only while the skid holds a result,
// and the whole pipeline then holds with nothing lost or repeated.
// Reset clears all valid bits and the skid; no request is in flight after
// reset and in_ready_o is high.
// FRAC_BITS sets the fixed-point fraction width (12 to 24).
module rgb_contrast_lightness_adjust import rcla_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAN_W-1:0] red_in_i,
  input  logic [CHAN_W-1:0] green_in_i,
  input  logic [CHAN_W-1:0] blue_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAN_W-1:0] red_out_o,
  output logic [CHAN_W-1:0] green_out_o,
  output logic [CHAN_W-1:0] blue_out_o
);

`include "assert_macros.svh"

  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned DLAT  = F + 3;
  localparam int unsigned S_NW  = 8 + F;
  localparam int unsigned H_NW  = 11 + F;
  localparam int unsigned HW    = F + 3;
  localparam int unsigned L_SH  = 21;

  localparam logic [HW-1:0] ONE   = HW'(1) << F;
  localparam logic [HW-1:0] TWO   = HW'(2) << F;
  localparam logic [HW-1:0] THREE = HW'(3) << F;
  localparam logic [HW-1:0] FOUR  = HW'(4) << F;
  localparam logic [HW:0]   SIX   = (HW+1)'(6) << F;
  localparam logic [F+10:0] L_MUL =
    (F+11)'(((64'd1 << (F + L_SH)) + 64'd1274) / 64'd1275);

  pipe_ctl_t ctl;
  logic      skid_full_q;

  assign ctl.en     = !skid_full_q;
  assign in_ready_o = ctl.en;

  function automatic logic [7:0] stretch(input logic [7:0] c);
    logic [10:0] v;
    logic [10:0] t;
    logic [8:0]  sh;
    v  = {1'b0, c, 2'b00} + {2'b00, c, 1'b0};
    t  = v - 11'd255;
    sh = t[10:2];
    if (v < 11'd255) begin
      stretch = '0;
    end else if (sh > 9'd255) begin
      stretch = 8'd255;
    end else begin
      stretch = sh[7:0];
    end
  endfunction

  // stage 1: contrast stretch
  logic       v1_q;
  logic [7:0] r1_q, g1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (ctl.en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      r1_q <= stretch(red_in_i);
      g1_q <= stretch(green_in_i);
      b1_q <= stretch(blue_in_i);
    end
  end

  // stage 2: max, min, divider operands
  logic [7:0]      mx, mn, d;
  logic [8:0]      sum;
  logic [10:0]     n, d11;
  logic [8:0]      sden;
  logic [7:0]      hden;
  logic            v2_q;
  logic [S_NW-1:0] snum_q;
  logic [8:0]      sden_q;
  logic [H_NW-1:0] hnum_q;
  logic [7:0]      hden_q;
  logic [8:0]      lsum_q;

  always_comb begin
    mx = r1_q;
    mn = r1_q;
    if (g1_q > mx) mx = g1_q;
    if (b1_q > mx) mx = b1_q;
    if (g1_q < mn) mn = g1_q;
    if (b1_q < mn) mn = b1_q;
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    d11 = {3'b000, d};
    if (mx == r1_q) begin
      n = {3'b000, g1_q} - {3'b000, b1_q};
      if (g1_q < b1_q) n = n + (d11 << 2) + (d11 << 1);
    end else if (mx == g1_q) begin
      n = (d11 << 1) + {3'b000, b1_q} - {3'b000, r1_q};
    end else begin
      n = (d11 << 2) + {3'b000, r1_q} - {3'b000, g1_q};
    end
    if (sum <= 9'd255) begin
      sden = sum;
    end else begin
      sden = 9'd510 - sum;
    end
    hden = d;
    if (d == '0) begin
      sden = 9'd1;
      hden = 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ctl.en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      snum_q <= S_NW'(d) << F;
      sden_q <= sden;
      hnum_q <= H_NW'(n) << F;
      hden_q <= hden;
      lsum_q <= sum;
    end
  end

  // dividers
  logic [F:0]      s_w;
  logic [HW-1:0]   h_w;
  logic [F-1:0]    l_w;
  logic [DLAT-1:0] vd_q;
  logic [F+20:0]   lprod;
  logic [F-1:0]    ld_q [DLAT];

  rcla_div #(.NW(S_NW), .DW(9), .QW(F + 1), .STAGES(DLAT)) u_div_s (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .num_i (snum_q),
    .den_i (sden_q),
    .quo_o (s_w)
  );

  rcla_div #(.NW(H_NW), .DW(8), .QW(HW), .STAGES(DLAT)) u_div_h (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .num_i (hnum_q),
    .den_i (hden_q),
    .quo_o (h_w)
  );

  assign lprod = (F+21)'({lsum_q, 1'b0}) * (F+21)'(L_MUL);

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      ld_q[0] <= lprod[F+20:L_SH];
      for (int k = 1; k < DLAT; k++) begin
        ld_q[k] <= ld_q[k-1];
      end
    end
  end

  assign l_w = ld_q[DLAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else if (ctl.en) begin
      vd_q <= {vd_q[DLAT-2:0], v2_q};
    end
  end

  // stage 3: L * S
  logic [2*F:0]  ls_full;
  logic          v3_q;
  logic [F:0]    s3_q, ls3_q;
  logic [F-1:0]  l3_q;
  logic [HW-1:0] h3_q;

  assign ls_full = (2*F+1)'(l_w) * (2*F+1)'(s_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (ctl.en) begin
      v3_q <= vd_q[DLAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      s3_q  <= s_w;
      l3_q  <= l_w;
      h3_q  <= h_w;
      ls3_q <= ls_full[2*F:F];
    end
  end

  // stage 4: q, p and per-channel hue offsets
  logic [F+1:0]   q4, diff4;
  logic signed [HW-1:0] p4s;
  logic [F+1:0]   p4;
  logic [HW-1:0]  t4 [NUM_CHAN];
  logic [HW:0]    tr;
  level_sel_e     sel4 [NUM_CHAN];
  logic [F:0]     m4 [NUM_CHAN];

  logic           v4_q;
  logic [F+1:0]   q4_q, p4_q, diff4_q;
  level_sel_e     sel4_q [NUM_CHAN];
  logic [F:0]     m4_q [NUM_CHAN];

  always_comb begin
    if (!l3_q[F-1]) begin
      q4 = (F+2)'(l3_q) + (F+2)'(ls3_q);
    end else begin
      q4 = (F+2)'(l3_q) + (F+2)'(s3_q) - (F+2)'(ls3_q);
    end
    p4s = $signed(HW'({l3_q, 1'b0})) - $signed(HW'(q4));
    if (p4s < 0) begin
      p4 = '0;
    end else begin
      p4 = p4s[F+1:0];
    end
    if (q4 < p4) q4 = p4;
    diff4 = q4 - p4;

    tr = (HW+1)'(h3_q) + (HW+1)'(TWO);
    if (tr >= SIX) tr = tr - SIX;
    t4[0] = tr[HW-1:0];
    t4[1] = h3_q;
    if (h3_q < TWO) begin
      t4[2] = h3_q + FOUR;
    end else begin
      t4[2] = h3_q - TWO;
    end

    for (int c = 0; c < NUM_CHAN; c++) begin
      m4[c] = '0;
      if (t4[c] <= ONE) begin
        sel4[c] = LVL_RISE;
        m4[c]   = t4[c][F:0];
      end else if (t4[c] <= THREE) begin
        sel4[c] = LVL_HIGH;
      end else if (t4[c] <= FOUR) begin
        sel4[c] = LVL_FALL;
        m4[c]   = (F+1)'(FOUR - t4[c]);
      end else begin
        sel4[c] = LVL_LOW;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (ctl.en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      q4_q    <= q4;
      p4_q    <= p4;
      diff4_q <= diff4;
      for (int c = 0; c < NUM_CHAN; c++) begin
        sel4_q[c] <= sel4[c];
        m4_q[c]   <= m4[c];
      end
    end
  end

  // stage 5: channel level, clamped to one
  logic [2*F+2:0] prod5 [NUM_CHAN];
  logic [F+1:0]   x5 [NUM_CHAN];
  logic           v5_q;
  logic [F:0]     x5_q [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      prod5[c] = (2*F+3)'(m4_q[c]) * (2*F+3)'(diff4_q);
      case (sel4_q[c])
        LVL_RISE, LVL_FALL: x5[c] = p4_q + prod5[c][2*F+1:F];
        LVL_HIGH:           x5[c] = q4_q;
        LVL_LOW:            x5[c] = p4_q;
        default:            x5[c] = p4_q;
      endcase
      if (x5[c] > (F+2)'(ONE)) x5[c] = (F+2)'(ONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (ctl.en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        x5_q[c] <= x5[c][F:0];
      end
    end
  end

  // stage 6: scale to a byte
  logic [F+8:0]      y6 [NUM_CHAN];
  logic [F+8:0]      yb6 [NUM_CHAN];
  logic              v6_q;
  logic [CHAN_W-1:0] o6_q [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      y6[c]  = ((F+9)'(x5_q[c]) << 8) - (F+9)'(x5_q[c]);
      yb6[c] = y6[c] >> F;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (ctl.en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.en) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        if (yb6[c] > (F+9)'(255)) begin
          o6_q[c] <= 8'd255;
        end else begin
          o6_q[c] <= yb6[c][CHAN_W-1:0];
        end
      end
    end
  end

  // output register and skid
  logic              out_valid_q;
  logic [CHAN_W-1:0] out_q [NUM_CHAN];
  logic [CHAN_W-1:0] skid_q [NUM_CHAN];
  logic              push;

  assign push = v6_q && ctl.en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (out_valid_q && !out_ready_i) begin
      if (push) skid_full_q <= 1'b1;
    end else if (skid_full_q) begin
      out_valid_q <= 1'b1;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !out_ready_i) begin
      if (push) skid_q <= o6_q;
    end else if (skid_full_q) begin
      out_q <= skid_q;
    end else if (push) begin
      out_q <= o6_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];

  `ASSERT_IMPL(a_skid_needs_out, skid_full_q, out_valid_q, "skid full without output")
  `ASSERT_IMPL(a_skid_rise, $rose(skid_full_q), $past(out_valid_q && !out_ready_i), "skid filled while output free")
  `ASSERT_NEXT(a_stall_to_skid, push && out_valid_q && !out_ready_i, skid_full_q, "stalled result dropped")

endmodule
